### rtl/core/smdb_pkg.sv
// ---------------------------------------------------------------------------
// smdb_pkg: shared types and constants of the masked dither blitter
// Screen geometry, configuration image, queue entry layout and dither lookup.
// ---------------------------------------------------------------------------
package smdb_pkg;

    localparam int LINE_WORDS    = 40;
    localparam int VISIBLE_WORDS = 20;
    localparam int ADDR_W        = 21;
    localparam int WORD_W        = 16;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    // Line step and the correction for a row that wraps from -1024 to 1023.
    localparam logic [ADDR_W-1:0] LINE_STEP    = ADDR_W'(LINE_WORDS);
    localparam logic [ADDR_W-1:0] ROW_WRAP_ADJ = ADDR_W'((2048 * LINE_WORDS) % (2 ** ADDR_W));

    typedef enum logic [2:0] {
        CFG_ORIGIN_X    = 3'd0,
        CFG_BOTTOM_ROW  = 3'd1,
        CFG_WIDTH_WORDS = 3'd2,
        CFG_HALF_HEIGHT = 3'd3,
        CFG_DITHER_LOW  = 3'd4,
        CFG_DITHER_HIGH = 3'd5,
        CFG_SCREEN_BASE = 3'd6
    } cfg_index_t;

    // Write slot of one queued word: main pair, then flush pair.
    typedef enum logic [1:0] {
        PH_MAIN_LO  = 2'd0,
        PH_MAIN_HI  = 2'd1,
        PH_FLUSH_LO = 2'd2,
        PH_FLUSH_HI = 2'd3
    } phase_t;

    typedef struct packed {
        logic [10:0]       origin_x;
        logic [9:0]        bottom_row;
        logic [5:0]        width_words;
        logic [8:0]        half_height;
        logic [63:0]       dither_low;
        logic [15:0]       dither_high;
        logic [ADDR_W-1:0] screen_base;
    } cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] line_off;   // sign-extended row times LINE_WORDS
        logic              row_wrap;   // row is -1024, line above wraps to 1023
        logic [1:0]        sel;        // row & 3
        logic [6:0]        col_main;
        logic [6:0]        col_flush;
        logic [WORD_W-1:0] mask_main;
        logic [WORD_W-1:0] mask_flush;
        logic              main_vis;
        logic              flush_vis;  // row ends and flush column is visible
        logic              shape_end;
    } job_t;

    function automatic logic [WORD_W-1:0] dither_pick(
        input logic [63:0]       lo,
        input logic [15:0]       hi,
        input logic [2:0]        k
    );
        logic [WORD_W-1:0] r;
        case (k)
            3'd0:    r = lo[15:0];
            3'd1:    r = lo[31:16];
            3'd2:    r = lo[47:32];
            3'd3:    r = lo[63:48];
            default: r = hi;
        endcase
        return r;
    endfunction

endpackage

### rtl/core/smdb_channels.sv
// ---------------------------------------------------------------------------
// smdb channels: valid/ready interfaces of the blitter
// Mask word input channel and masked screen write output channel.
// ---------------------------------------------------------------------------
interface smdb_mask_if;
    logic                      valid;
    logic                      ready;
    logic [smdb_pkg::WORD_W-1:0] mask_word;

    modport source (output valid, output mask_word, input ready);
    modport sink   (input valid, input mask_word, output ready);
endinterface

interface smdb_write_if;
    logic                        valid;
    logic                        ready;
    logic [smdb_pkg::ADDR_W-1:0] word_address;
    logic [smdb_pkg::WORD_W-1:0] pixel_data;
    logic [smdb_pkg::WORD_W-1:0] write_mask;
    logic                        run_last;
    logic                        shape_done;

    modport source (output valid, output word_address, output pixel_data,
                    output write_mask, output run_last, output shape_done,
                    input ready);
    modport sink   (input valid, input word_address, input pixel_data,
                    input write_mask, input run_last, input shape_done,
                    output ready);
endinterface

### rtl/core/smdb_front.sv
// ---------------------------------------------------------------------------
// smdb_front: mask word intake and classification
// Tracks row/column position, funnel-shifts each word and queues its writes.
// ---------------------------------------------------------------------------
module smdb_front (
    input  logic               clk,
    input  logic               rst_n,
    input  smdb_pkg::cfg_t     cfg,
    smdb_mask_if.sink          mask_ch,
    input  logic               q_full,
    output logic               push,
    output smdb_pkg::job_t     push_job
);

    logic [15:0] leftover_reg, leftover_next;
    logic [5:0]  column_reg, column_next;
    logic [8:0]  row_count_reg, row_count_next;
    logic [10:0] cur_row_reg, cur_row_next;

    logic [5:0]  w;
    logic [8:0]  h;
    logic [3:0]  p;
    logic [6:0]  xw;
    logic [10:0] row;
    logic [15:0] lo;
    logic [31:0] funnel;
    logic [8:0]  col_s;
    logic        row_end;
    logic        shape_end;

    assign mask_ch.ready = !q_full;
    assign push          = mask_ch.valid && !q_full;

    always_comb
    begin
        w      = (cfg.width_words == 6'd0) ? 6'd1 : cfg.width_words;
        h      = (cfg.half_height == 9'd0) ? 9'd1 : cfg.half_height;
        p      = cfg.origin_x[3:0];
        xw     = cfg.origin_x[10:4];
        row    = (column_reg == 6'd0 && row_count_reg == 9'd0)
                 ? {1'b0, cfg.bottom_row} : cur_row_reg;
        lo     = (column_reg == 6'd0) ? 16'd0 : leftover_reg;
        funnel = {mask_ch.mask_word, lo} >> p;
        col_s  = {{2{xw[6]}}, xw} + {3'b000, w} - {3'b000, column_reg};

        row_end   = ({1'b0, column_reg} + 7'd1) >= {1'b0, w};
        shape_end = row_end && (({1'b0, row_count_reg} + 10'd1) >= {1'b0, h});

        push_job.line_off   = smdb_pkg::ADDR_W'({{10{row[10]}}, row} * smdb_pkg::LINE_STEP);
        push_job.row_wrap   = (row == 11'h400);
        push_job.sel        = row[1:0];
        push_job.col_main   = col_s[6:0];
        push_job.col_flush  = xw;
        push_job.mask_main  = funnel[15:0];
        push_job.mask_flush = mask_ch.mask_word >> p;
        push_job.main_vis   = !col_s[8]
                              && ({1'b0, col_s} < 10'(smdb_pkg::VISIBLE_WORDS));
        push_job.flush_vis  = row_end && !xw[6]
                              && ({3'b000, xw} < 10'(smdb_pkg::VISIBLE_WORDS));
        push_job.shape_end  = shape_end;

        leftover_next  = leftover_reg;
        column_next    = column_reg;
        row_count_next = row_count_reg;
        cur_row_next   = cur_row_reg;
        if (push)
        begin
            if (row_end)
            begin
                leftover_next  = 16'd0;
                column_next    = 6'd0;
                cur_row_next   = row - 11'd2;
                row_count_next = shape_end ? 9'd0 : row_count_reg + 9'd1;
            end
            else
            begin
                leftover_next = mask_ch.mask_word;
                column_next   = column_reg + 6'd1;
                cur_row_next  = row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leftover_reg  <= '0;
            column_reg    <= '0;
            row_count_reg <= '0;
            cur_row_reg   <= '0;
        end
        else
        begin
            leftover_reg  <= leftover_next;
            column_reg    <= column_next;
            row_count_reg <= row_count_next;
            cur_row_reg   <= cur_row_next;
        end
    end

endmodule

### rtl/core/smdb_queue.sv
// ---------------------------------------------------------------------------
// smdb_queue: short job queue between front and back
// Register FIFO; head entry is read in place by the back end.
// ---------------------------------------------------------------------------
module smdb_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  smdb_pkg::job_t   push_job,
    input  logic             pop,
    output logic             full,
    output logic             empty,
    output smdb_pkg::job_t   head
);

    smdb_pkg::job_t                  entry_reg [smdb_pkg::QUEUE_DEPTH];
    logic [smdb_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [smdb_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [smdb_pkg::QCNT_W-1:0]     count_reg, count_next;

    assign full  = (count_reg == smdb_pkg::QCNT_W'(smdb_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    function automatic logic [smdb_pkg::QPTR_W-1:0] ptr_inc(
        input logic [smdb_pkg::QPTR_W-1:0] ptr
    );
        logic [smdb_pkg::QPTR_W-1:0] r;
        if (ptr == smdb_pkg::QPTR_W'(smdb_pkg::QUEUE_DEPTH - 1))
            r = '0;
        else
            r = ptr + 1'b1;
        return r;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full && !pop |-> !push)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue popped while empty");
`endif

endmodule

### rtl/core/smdb_back.sv
// ---------------------------------------------------------------------------
// smdb_back: write sequencer
// Expands each queued word into up to four screen writes, one per cycle while the write port is ready.
// ---------------------------------------------------------------------------
module smdb_back (
    input  logic             clk,
    input  logic             rst_n,
    input  smdb_pkg::cfg_t   cfg,
    input  logic             empty,
    input  smdb_pkg::job_t   head,
    output logic             pop,
    smdb_write_if.source     write_ch
);

    smdb_pkg::phase_t              phase_reg, phase_next, ph;

    logic                          out_valid_reg, out_valid_next;
    logic [smdb_pkg::ADDR_W-1:0]   addr_reg;
    logic [smdb_pkg::WORD_W-1:0]   data_reg;
    logic [smdb_pkg::WORD_W-1:0]   mask_reg;
    logic                          last_reg;
    logic                          done_reg;

    logic                          upper;
    logic                          flush;
    logic                          active;
    logic                          is_last;
    logic                          slot_free;
    logic                          load;
    logic [6:0]                    col;
    logic [smdb_pkg::ADDR_W-1:0]   line;
    logic [2:0]                    dk;

    assign write_ch.valid        = out_valid_reg;
    assign write_ch.word_address = addr_reg;
    assign write_ch.pixel_data   = data_reg;
    assign write_ch.write_mask   = mask_reg;
    assign write_ch.run_last     = last_reg;
    assign write_ch.shape_done   = done_reg;

    always_comb
    begin
        // skip the main pair when its column is clipped
        ph = (phase_reg == smdb_pkg::PH_MAIN_LO && !head.main_vis)
             ? smdb_pkg::PH_FLUSH_LO : phase_reg;

        upper  = (ph == smdb_pkg::PH_MAIN_HI) || (ph == smdb_pkg::PH_FLUSH_HI);
        flush  = (ph == smdb_pkg::PH_FLUSH_LO) || (ph == smdb_pkg::PH_FLUSH_HI);
        active = flush ? head.flush_vis : 1'b1;
        is_last = (ph == smdb_pkg::PH_FLUSH_HI)
                  || (ph == smdb_pkg::PH_MAIN_HI && !head.flush_vis);

        slot_free = !out_valid_reg || write_ch.ready;
        load      = !empty && active && slot_free;
        pop       = !empty && (!active || (load && is_last));

        if (pop)
            phase_next = smdb_pkg::PH_MAIN_LO;
        else if (load)
            phase_next = smdb_pkg::phase_t'(ph + 2'd1);
        else
            phase_next = phase_reg;

        out_valid_next = load ? 1'b1 : (write_ch.ready ? 1'b0 : out_valid_reg);

        col  = flush ? head.col_flush : head.col_main;
        line = head.line_off;
        if (upper)
            line = head.line_off - smdb_pkg::LINE_STEP
                   + (head.row_wrap ? smdb_pkg::ROW_WRAP_ADJ : '0);
        dk = upper ? {1'b0, head.sel} : ({1'b0, head.sel} + 3'd1);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            addr_reg <= cfg.screen_base + line + {{(smdb_pkg::ADDR_W-7){1'b0}}, col};
            data_reg <= smdb_pkg::dither_pick(cfg.dither_low, cfg.dither_high, dk);
            mask_reg <= flush ? head.mask_flush : head.mask_main;
            last_reg <= is_last;
            done_reg <= is_last && head.shape_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= smdb_pkg::PH_MAIN_LO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_phase_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != smdb_pkg::PH_MAIN_LO) |-> !empty)
        else $error("write slot advanced with no job at queue head");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        write_ch.valid && write_ch.shape_done |-> write_ch.run_last)
        else $error("shape done flagged on a write that is not the word's last");
`endif

endmodule

### rtl/core/shifted_mask_dither_blitter_unit.sv
// ---------------------------------------------------------------------------
// shifted_mask_dither_blitter_unit: masked blit with barrel shift and dither
// Top level: configuration registers, front end, job queue and write sequencer.
// ---------------------------------------------------------------------------
// Feed shape mask words right to left, bottom row up, width_words per row.
// Each word is funnel-shifted by origin_x mod 16 and becomes a masked write
// pair (shape line, then line above) with dither data; a row's last word
// adds a flush pair one column left. Pairs outside the visible columns are
// dropped. Rate: the front accepts one beat per cycle while the two-entry
// job queue has room; the write port, one write beat per cycle while ready,
// sets the pace: a word makes two writes, four when a visible flush pair
// follows its own pair, none when fully clipped.
// The write channel has an output register, so a stalled write does not
// stop intake until the queue fills. Write configuration only while idle.
// ---------------------------------------------------------------------------
module shifted_mask_dither_blitter_unit (
    input  logic          clk,
    input  logic          rst_n,
    smdb_mask_if.sink     mask_ch,
    smdb_write_if.source  write_ch,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [63:0]   cfg_data
);

    smdb_pkg::cfg_t  cfg_reg, cfg_next;
    smdb_pkg::job_t  push_job;
    smdb_pkg::job_t  head;
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;

    // Register file: decode the index and keep only each register's width.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                smdb_pkg::CFG_ORIGIN_X:    cfg_next.origin_x    = cfg_data[10:0];
                smdb_pkg::CFG_BOTTOM_ROW:  cfg_next.bottom_row  = cfg_data[9:0];
                smdb_pkg::CFG_WIDTH_WORDS: cfg_next.width_words = cfg_data[5:0];
                smdb_pkg::CFG_HALF_HEIGHT: cfg_next.half_height = cfg_data[8:0];
                smdb_pkg::CFG_DITHER_LOW:  cfg_next.dither_low  = cfg_data;
                smdb_pkg::CFG_DITHER_HIGH: cfg_next.dither_high = cfg_data[15:0];
                smdb_pkg::CFG_SCREEN_BASE: cfg_next.screen_base = cfg_data[20:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    // Reset to a one-word, one-row shape; everything else clears.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{origin_x:    11'd0,
                         bottom_row:  10'd0,
                         width_words: 6'd1,
                         half_height: 9'd1,
                         dither_low:  64'd0,
                         dither_high: 16'd0,
                         screen_base: 21'd0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: track position, shift the word, classify its write pairs.
    smdb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .mask_ch  (mask_ch),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    // Queue: decouple intake from write-port stalls.
    smdb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (head)
    );

    // Back: issue write beats, one per cycle while the write port is ready, through the output register.
    smdb_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .empty    (q_empty),
        .head     (head),
        .pop      (pop),
        .write_ch (write_ch)
    );

endmodule

### dv/shifted_mask_dither_blitter_unit_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// shifted_mask_dither_blitter_unit_tb: self-checking bench of the blitter
// Feeds mask word beats under several shape settings, predicts every masked
// screen write in order, and checks each write beat field by field.
// ---------------------------------------------------------------------------
module shifted_mask_dither_blitter_unit_tb;
    import smdb_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int SETTLE_CYCLES = 16;   // queue depth plus output register, with margin
    localparam int RANDOM_TARGET = 260;  // words sent before the quiet tail starts
    localparam int MAX_BURST     = 70;   // cap on words per random shape

    // One predicted screen write, laid out like the write channel payload.
    typedef struct packed {
        logic [ADDR_W-1:0] word_address;
        logic [WORD_W-1:0] pixel_data;
        logic [WORD_W-1:0] write_mask;
        logic              run_last;
        logic              shape_done;
    } screen_write_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    smdb_mask_if  mask_ch ();
    smdb_write_if write_ch ();

    shifted_mask_dither_blitter_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .mask_ch   (mask_ch),
        .write_ch  (write_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Writes still owed by the block, oldest first.
    screen_write_t pending_writes[$];

    // Shadow of the register file and of the blitter's walk through a shape.
    cfg_t        shadow_cfg;
    logic [15:0] carry_word;   // previous word of the current shape row
    logic [5:0]  col_cnt;
    logic [8:0]  row_cnt;
    logic [10:0] cur_row;      // signed screen row of the current shape row

    int error_count = 0;
    int words_sent  = 0;
    int stall_left  = 0;
    bit gaps_on     = 1'b1;
    bit stalls_on   = 1'b1;

    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    // -----------------------------------------------------------------------
    // Prediction
    // -----------------------------------------------------------------------

    // Entry k of the five-entry dither table.
    function automatic logic [15:0] dither_word(input int k);
        if (k >= 4)
            return shadow_cfg.dither_high;
        return shadow_cfg.dither_low[16*k +: 16];
    endfunction

    // Word address of column col on a signed 11-bit line; wraps mod 2^21.
    function automatic logic [ADDR_W-1:0] line_addr(input logic [10:0] row, input int col);
        int a;
        a = int'(shadow_cfg.screen_base) + int'($signed(row)) * LINE_WORDS + col;
        return a[ADDR_W-1:0];
    endfunction

    // Queue the write pair for one column: shape line first, then the line above.
    // Drop the pair when the column lies off the visible screen.
    function automatic void push_pair(input int col, input logic [15:0] m);
        screen_write_t w;
        logic [10:0]   above;
        if (col < 0 || col >= VISIBLE_WORDS)
            return;
        above          = cur_row - 11'd1;
        w.word_address = line_addr(cur_row, col);
        w.pixel_data   = dither_word(int'(cur_row[1:0]) + 1);
        w.write_mask   = m;
        w.run_last     = 1'b0;
        w.shape_done   = 1'b0;
        pending_writes.push_back(w);
        w.word_address = line_addr(above, col);
        w.pixel_data   = dither_word(int'(cur_row[1:0]));
        pending_writes.push_back(w);
    endfunction

    // Advance the shape walk by one accepted mask word and queue its writes.
    function automatic void predict_blit(input logic [15:0] word);
        int            w_eff;
        int            h_eff;
        int            p;
        int            xw;
        int            col;
        int            start_len;
        logic [31:0]   shifted;
        bit            shape_end;
        screen_write_t tail;
        w_eff = (shadow_cfg.width_words == 0) ? 1 : int'(shadow_cfg.width_words);
        h_eff = (shadow_cfg.half_height == 0) ? 1 : int'(shadow_cfg.half_height);
        p     = int'(shadow_cfg.origin_x[3:0]);
        xw    = $signed(shadow_cfg.origin_x[10:4]);

        // A new shape starts at the bottom row; a new row starts with no carry.
        if (col_cnt == 0 && row_cnt == 0)
            cur_row = {1'b0, shadow_cfg.bottom_row};
        if (col_cnt == 0)
            carry_word = 16'h0;

        start_len = pending_writes.size();
        col       = xw + w_eff - int'(col_cnt);
        shifted   = ({16'h0, word} << (16 - p)) | ({16'h0, carry_word} >> p);
        push_pair(col, shifted[15:0]);

        shape_end = 1'b0;
        if (int'(col_cnt) + 1 >= w_eff)
        begin
            // Row ends: flush the bits shifted out of this word one column left.
            shifted = {16'h0, word} >> p;
            push_pair(xw, shifted[15:0]);
            shape_end  = int'(row_cnt) + 1 >= h_eff;
            col_cnt    = 6'd0;
            carry_word = 16'h0;
            cur_row    = cur_row - 11'd2;
            row_cnt    = shape_end ? 9'd0 : row_cnt + 9'd1;
        end
        else
        begin
            col_cnt    = col_cnt + 6'd1;
            carry_word = word;
        end

        // Mark the last write of this word.
        if (pending_writes.size() > start_len)
        begin
            tail            = pending_writes.pop_back();
            tail.run_last   = 1'b1;
            tail.shape_done = shape_end;
            pending_writes.push_back(tail);
        end
    endfunction

    // -----------------------------------------------------------------------
    // Write channel: check each beat, drive ready with random stall bursts
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin : write_sink
        screen_write_t got;
        screen_write_t want;
        if (!rst_n)
            write_ch.ready <= 1'b0;
        else
        begin
            if (write_ch.valid && write_ch.ready)
            begin
                got.word_address = write_ch.word_address;
                got.pixel_data   = write_ch.pixel_data;
                got.write_mask   = write_ch.write_mask;
                got.run_last     = write_ch.run_last;
                got.shape_done   = write_ch.shape_done;
                if (pending_writes.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected write beat addr=%h data=%h mask=%h last=%b done=%b",
                             $time, got.word_address, got.pixel_data, got.write_mask,
                             got.run_last, got.shape_done);
                end
                else
                begin
                    want = pending_writes.pop_front();
                    if (got !== want)
                    begin
                        error_count++;
                        $display("%0t: write mismatch expected addr=%h data=%h mask=%h last=%b done=%b",
                                 $time, want.word_address, want.pixel_data, want.write_mask,
                                 want.run_last, want.shape_done);
                        $display("%0t:                  actual addr=%h data=%h mask=%h last=%b done=%b",
                                 $time, got.word_address, got.pixel_data, got.write_mask,
                                 got.run_last, got.shape_done);
                    end
                end
            end

            // Hold ready low through a burst, otherwise maybe start a new one.
            if (stall_left > 0)
            begin
                stall_left--;
                write_ch.ready <= 1'b0;
            end
            else if (stalls_on && $urandom_range(0, 3) == 0)
            begin
                stall_left = $urandom_range(1, 5) - 1;
                write_ch.ready <= 1'b0;
            end
            else
                write_ch.ready <= 1'b1;
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------

    // Present one mask word beat and wait for it to be taken. Valid stays high
    // afterwards so that back-to-back beats follow without a gap.
    task automatic send_mask(input logic [15:0] word);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            mask_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        mask_ch.valid     <= 1'b1;
        mask_ch.mask_word <= word;
        @(posedge clk);
        while (!mask_ch.ready)
            @(posedge clk);
        predict_blit(word);
        words_sent++;
    endtask

    // Drop valid, wait for every owed write, then let clipped words drain.
    task automatic wait_for_writes();
        mask_ch.valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input cfg_index_t idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // Write the whole register file; call only while the block is idle.
    task automatic apply_config(input cfg_t c);
        put_reg(CFG_ORIGIN_X,    64'(c.origin_x));
        put_reg(CFG_BOTTOM_ROW,  64'(c.bottom_row));
        put_reg(CFG_WIDTH_WORDS, 64'(c.width_words));
        put_reg(CFG_HALF_HEIGHT, 64'(c.half_height));
        put_reg(CFG_DITHER_LOW,  c.dither_low);
        put_reg(CFG_DITHER_HIGH, 64'(c.dither_high));
        put_reg(CFG_SCREEN_BASE, 64'(c.screen_base));
        cfg_we     <= 1'b0;
        shadow_cfg  = c;
    endtask

    // Shape geometry as given, random dither table.
    function automatic cfg_t shape_config(input logic [10:0] ox, input logic [9:0] row,
                                          input logic [5:0] w, input logic [8:0] h,
                                          input logic [ADDR_W-1:0] base);
        cfg_t c;
        c.origin_x    = ox;
        c.bottom_row  = row;
        c.width_words = w;
        c.half_height = h;
        c.dither_low  = {$urandom, $urandom};
        c.dither_high = 16'($urandom);
        c.screen_base = base;
        return c;
    endfunction

    // Mostly on-screen origins and small shapes; now and then the extremes.
    function automatic cfg_t random_config();
        cfg_t c;
        int   pick;
        c = shape_config(11'($urandom_range(0, 400) - 80), 10'($urandom_range(0, 1023)),
                         6'($urandom_range(1, 4)), 9'($urandom_range(1, 4)),
                         ADDR_W'($urandom));
        if ($urandom_range(0, 4) == 0)
            c.origin_x = 11'($urandom);
        pick = $urandom_range(0, 19);
        if (pick == 0)
            c.width_words = 6'd0;
        else if (pick == 1)
            c.width_words = 6'd63;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            c.half_height = 9'd0;
        else if (pick == 1)
            c.half_height = 9'd511;
        if ($urandom_range(0, 9) == 0)
            c.screen_base = {ADDR_W{1'b1}};
        return c;
    endfunction

    function automatic logic [15:0] random_mask();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h1 << $urandom_range(0, 15);
            default: return 16'($urandom);
        endcase
    endfunction

    // Words that make up one whole shape under the current settings.
    function automatic int shape_words(input cfg_t c);
        int w_eff;
        int h_eff;
        w_eff = (c.width_words == 0) ? 1 : int'(c.width_words);
        h_eff = (c.half_height == 0) ? 1 : int'(c.half_height);
        return w_eff * h_eff;
    endfunction

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // Reset settings: one-word shape at the screen origin, zero dither.
    task automatic test_reset_state();
        send_mask(16'hFFFF);
        send_mask(16'h8001);
        wait_for_writes();
    endtask

    // Funnel shift across a three-word row, two rows from line 0 so the upper
    // lines sit above the screen, with the address wrapping past the top.
    task automatic test_shift_and_wrap();
        apply_config(shape_config(11'd5, 10'd0, 6'd3, 9'd2, 21'h1FFFF0));
        send_mask(16'hFFFF);
        send_mask(16'h8000);
        send_mask(16'h0001);
        send_mask(16'hA5A5);
        send_mask(16'h0000);
        send_mask(16'h5A5A);
        wait_for_writes();
    endtask

    // Origins at both ends of the range and shapes straddling the left and
    // right screen edges; fully clipped words must produce nothing.
    task automatic test_clip_edges();
        apply_config(shape_config(11'h400, 10'd7, 6'd2, 9'd1, 21'd0));
        send_mask(16'hFFFF);
        send_mask(16'h1234);
        wait_for_writes();
        apply_config(shape_config(11'h3FF, 10'd100, 6'd1, 9'd1, 21'd0));
        send_mask(16'hFFFF);
        wait_for_writes();
        apply_config(shape_config(-11'sd8, 10'd1023, 6'd2, 9'd1, 21'h0ABCDE));
        send_mask(16'hF00F);
        send_mask(16'h0FF0);
        wait_for_writes();
        apply_config(shape_config(11'd304, 10'd50, 6'd1, 9'd1, 21'd0));
        send_mask(16'hC003);
        wait_for_writes();
    endtask

    // Zero width and zero height both behave as one.
    task automatic test_zero_size();
        apply_config(shape_config(11'd40, 10'd9, 6'd0, 9'd0, 21'h000100));
        send_mask(16'h7FFE);
        send_mask(16'h8000);
        wait_for_writes();
    endtask

    // Tallest shape, cut short by shrinking width and height mid-row.
    task automatic test_resize_mid_shape();
        cfg_t c;
        apply_config(shape_config(11'd19, 10'd512, 6'd2, 9'd511, 21'h012345));
        send_mask(16'h00FF);
        send_mask(16'hFF00);
        send_mask(16'h3C3C);
        wait_for_writes();
        c             = shadow_cfg;
        c.width_words = 6'd1;
        c.half_height = 9'd1;
        apply_config(c);
        send_mask(16'hE007);
        send_mask(16'h0180);
        wait_for_writes();
    endtask

    // Random settings, mostly whole shapes, some cut short or run over.
    // Idle phases are mixed in so that gaps and stalls land everywhere.
    task automatic test_random_shapes();
        cfg_t c;
        int   n_words;
        while (words_sent < RANDOM_TARGET)
        begin
            gaps_on   = $urandom_range(0, 3) != 0;
            stalls_on = $urandom_range(0, 3) != 0;
            c = random_config();
            apply_config(c);
            n_words = shape_words(c);
            if (n_words > MAX_BURST)
                n_words = MAX_BURST;
            if ($urandom_range(0, 5) == 0)
                n_words = $urandom_range(1, n_words + 3);
            repeat (n_words)
            begin
                send_mask(random_mask());
                // Now and then hold off mid-shape until the block runs dry.
                if ($urandom_range(0, 39) == 0)
                    wait_for_writes();
            end
            wait_for_writes();
        end
    endtask

    // Full-rate tail: no gaps, no stalls, whole shapes.
    task automatic test_full_rate_tail();
        cfg_t c;
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        repeat (2)
        begin
            c             = random_config();
            c.origin_x    = 11'($urandom_range(0, 240));
            c.width_words = 6'($urandom_range(2, 4));
            c.half_height = 9'($urandom_range(3, 5));
            apply_config(c);
            repeat (shape_words(c))
                send_mask(random_mask());
            wait_for_writes();
        end
    endtask

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial
    begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_ORIGIN_X;
        cfg_data          <= 64'h0;
        mask_ch.valid     <= 1'b0;
        mask_ch.mask_word <= 16'h0;

        shadow_cfg             = '0;
        shadow_cfg.width_words = 6'd1;
        shadow_cfg.half_height = 9'd1;
        carry_word             = 16'h0;
        col_cnt                = 6'd0;
        row_cnt                = 9'd0;
        cur_row                = 11'd0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_shift_and_wrap();
        test_clip_edges();
        test_zero_size();
        test_resize_mid_shape();
        test_random_shapes();
        test_full_rate_tail();

        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
